// ----- design/wbcs_pkg.sv -----
// Shared types, constants and register codes for the white blob centroid steering block.
package wbcs_pkg;

  localparam int unsigned WIDTH_W    = 11;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned SCALE_W    = 15;
  localparam int unsigned COLUMN_W   = 10;
  localparam int unsigned COUNT_W    = 21;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Product and quotient widths of the back end
  localparam int unsigned MAG_W  = SCALE_W + SUM_W;        // turn_scale * |sum|
  localparam int unsigned DEN_W  = COUNT_W + WIDTH_W + 1;  // 2 * count * width
  localparam int unsigned QUO_W  = RATE_W;
  localparam int unsigned STEP_W = $clog2(QUO_W);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH   = 11'd640;
  localparam logic [LEVEL_W-1:0] RST_WHITE_LEVEL   = 8'd255;
  localparam logic [SPEED_W-1:0] RST_FORWARD_SPEED = 16'd128;
  localparam logic [SCALE_W-1:0] RST_TURN_SCALE    = 15'd12868;

  localparam int unsigned FIFO_DEPTH_DEF = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_WHITE_LEVEL   = 2'd1,
    REG_FORWARD_SPEED = 2'd2,
    REG_TURN_SCALE    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  red_level;
    logic [LEVEL_W-1:0]  green_level;
    logic [LEVEL_W-1:0]  blue_level;
    logic [COLUMN_W-1:0] column;
    logic                end_of_frame;
  } pixel_t;

  typedef struct packed {
    logic                     ball_found;
    logic [SPEED_W-1:0]       linear_speed;
    logic signed [RATE_W-1:0] angular_rate;
    logic [COUNT_W-1:0]       white_count;
  } cmd_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] image_width;
    logic [LEVEL_W-1:0] white_level;
    logic [SPEED_W-1:0] forward_speed;
    logic [SCALE_W-1:0] turn_scale;
  } cfg_t;

  // Frame totals handed from front to back
  typedef struct packed {
    logic signed [SUM_W-1:0] offset_sum;
    logic [COUNT_W-1:0]      pixel_count;
  } frame_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL_NUM,
    BK_MUL_DEN,
    BK_CHECK,
    BK_DIVIDE,
    BK_RESULT
  } back_state_t;

endpackage

// ----- design/wbcs_front.sv -----
// Front end: takes pixels, classifies white ones and accumulates frame totals.
module wbcs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  wbcs_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  wbcs_pkg::pixel_t    in_data,
  input  logic                q_full,
  output logic                q_push,
  output wbcs_pkg::frame_t    q_wdata
);

  logic signed [wbcs_pkg::SUM_W-1:0]   sum_r, sum_nxt, sum_acc;
  logic [wbcs_pkg::COUNT_W-1:0]        count_r, count_nxt, count_acc;
  logic                                accept;
  logic                                is_white;
  logic signed [wbcs_pkg::WIDTH_W:0]   offset;
  logic signed [wbcs_pkg::SUM_W:0]     sum_ext;

  // Stall the whole stream while the frame queue is full
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify the pixel
  assign is_white = (in_data.red_level   == cfg.white_level) &&
                    (in_data.green_level == cfg.white_level) &&
                    (in_data.blue_level  == cfg.white_level) &&
                    (count_r != wbcs_pkg::COUNT_MAX);

  // Doubled centre offset and saturating add
  assign offset  = $signed({1'b0, in_data.column, 1'b0}) - $signed({1'b0, cfg.image_width});
  assign sum_ext = {sum_r[wbcs_pkg::SUM_W-1], sum_r} +
                   {{(wbcs_pkg::SUM_W - wbcs_pkg::WIDTH_W){offset[wbcs_pkg::WIDTH_W]}}, offset};

  always_comb begin
    sum_acc   = sum_r;
    count_acc = count_r;
    if (is_white) begin
      count_acc = count_r + 1'b1;
      if (sum_ext[wbcs_pkg::SUM_W] != sum_ext[wbcs_pkg::SUM_W-1]) begin
        sum_acc = sum_ext[wbcs_pkg::SUM_W] ? {1'b1, {(wbcs_pkg::SUM_W-1){1'b0}}}
                                           : {1'b0, {(wbcs_pkg::SUM_W-1){1'b1}}};
      end else begin
        sum_acc = sum_ext[wbcs_pkg::SUM_W-1:0];
      end
    end
  end

  // Hand totals over at frame end, then clear
  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    q_push    = 1'b0;
    if (accept) begin
      if (in_data.end_of_frame) begin
        q_push    = 1'b1;
        sum_nxt   = '0;
        count_nxt = '0;
      end else begin
        sum_nxt   = sum_acc;
        count_nxt = count_acc;
      end
    end
  end

  assign q_wdata.offset_sum  = sum_acc;
  assign q_wdata.pixel_count = count_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- design/wbcs_queue.sv -----
// Short queue of frame totals between the front and back ends.
module wbcs_queue #(
  parameter int unsigned DEPTH = wbcs_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wbcs_pkg::frame_t wdata,
  output logic             full,
  input  logic             pop,
  output logic             rvalid,
  output wbcs_pkg::frame_t rdata
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  wbcs_pkg::frame_t   slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               do_push, do_pop;

  assign full    = (fill_r == CNT_W'(DEPTH));
  assign rvalid  = (fill_r != '0);
  assign rdata   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;

  // Advance pointers with wrap at the last slot
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store the slot payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- design/wbcs_back.sv -----
// Back end: turns frame totals into a drive command with a bit-serial divider.
module wbcs_back (
  input  logic             clk,
  input  logic             rst_n,
  input  wbcs_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  wbcs_pkg::frame_t q_rdata,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output wbcs_pkg::cmd_t   out_data
);

  localparam int unsigned MAG_W  = wbcs_pkg::MAG_W;
  localparam int unsigned DEN_W  = wbcs_pkg::DEN_W;
  localparam int unsigned QUO_W  = wbcs_pkg::QUO_W;
  localparam int unsigned STEP_W = wbcs_pkg::STEP_W;
  localparam int unsigned DVS_W  = DEN_W + QUO_W - 1;
  localparam int unsigned PRD_W  = DEN_W - 1;

  wbcs_pkg::back_state_t state_r, state_nxt;

  logic signed [wbcs_pkg::SUM_W-1:0] sum_r;
  logic [wbcs_pkg::COUNT_W-1:0]      count_r;
  logic [wbcs_pkg::SUM_W-1:0]        abs_sum;
  logic                              neg_r, skip_r, sat_r;
  logic [MAG_W-1:0]                  mag_r, rem_r;
  logic [DEN_W-1:0]                  den_r;
  logic [DVS_W-1:0]                  dvs_r;
  logic [QUO_W-1:0]                  quo_r;
  logic [STEP_W-1:0]                 step_r;
  logic                              sat_cmp, fits;
  logic                              out_load;
  logic                              out_valid_r;
  wbcs_pkg::cmd_t                    out_data_r;
  logic signed [wbcs_pkg::RATE_W-1:0] rate;

  assign abs_sum = sum_r[wbcs_pkg::SUM_W-1] ? wbcs_pkg::SUM_W'(-sum_r)
                                             : wbcs_pkg::SUM_W'(sum_r);
  // Quotient needs more than sixteen bits: saturate
  assign sat_cmp = {2'b00, mag_r} >= {den_r, {QUO_W{1'b0}}};
  assign fits    = {1'b0, rem_r} >= dvs_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wbcs_pkg::BK_IDLE:    if (q_valid) state_nxt = wbcs_pkg::BK_MUL_NUM;
      wbcs_pkg::BK_MUL_NUM: state_nxt = wbcs_pkg::BK_MUL_DEN;
      wbcs_pkg::BK_MUL_DEN: state_nxt = wbcs_pkg::BK_CHECK;
      wbcs_pkg::BK_CHECK: begin
        state_nxt = (skip_r || sat_cmp) ? wbcs_pkg::BK_RESULT : wbcs_pkg::BK_DIVIDE;
      end
      wbcs_pkg::BK_DIVIDE:  if (step_r == '0) state_nxt = wbcs_pkg::BK_RESULT;
      wbcs_pkg::BK_RESULT:  if (out_load) state_nxt = wbcs_pkg::BK_IDLE;
      default:              state_nxt = wbcs_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      wbcs_pkg::BK_IDLE:   q_pop    = q_valid;
      wbcs_pkg::BK_RESULT: out_load = !out_valid_r || out_ready;
      default: begin
        q_pop    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wbcs_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath: multiply, range check, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    case (state_r)
      wbcs_pkg::BK_IDLE: begin
        sum_r   <= q_rdata.offset_sum;
        count_r <= q_rdata.pixel_count;
      end
      wbcs_pkg::BK_MUL_NUM: begin
        mag_r <= MAG_W'(cfg.turn_scale) * MAG_W'(abs_sum);
        neg_r <= !sum_r[wbcs_pkg::SUM_W-1] && (sum_r != '0);
      end
      wbcs_pkg::BK_MUL_DEN: begin
        den_r  <= {PRD_W'(count_r) * PRD_W'(cfg.image_width), 1'b0};
        skip_r <= (count_r == '0) || (cfg.image_width == '0);
      end
      wbcs_pkg::BK_CHECK: begin
        sat_r  <= sat_cmp;
        rem_r  <= mag_r;
        dvs_r  <= {den_r, {(QUO_W-1){1'b0}}};
        quo_r  <= '0;
        step_r <= STEP_W'(QUO_W - 1);
      end
      wbcs_pkg::BK_DIVIDE: begin
        if (fits) begin
          rem_r         <= rem_r - dvs_r[MAG_W-1:0];
          quo_r[step_r] <= 1'b1;
        end
        dvs_r  <= dvs_r >> 1;
        step_r <= step_r - 1'b1;
      end
      default: begin
        rem_r <= rem_r;
      end
    endcase
  end

  // Clamp the quotient to the signed output range
  always_comb begin
    if (skip_r) begin
      rate = '0;
    end else if (sat_r || quo_r[QUO_W-1]) begin
      rate = neg_r ? {1'b1, {(QUO_W-1){1'b0}}} : {1'b0, {(QUO_W-1){1'b1}}};
    end else begin
      rate = neg_r ? -$signed(quo_r) : $signed(quo_r);
    end
  end

  // Hold the command until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.ball_found   <= (count_r != '0);
      out_data_r.linear_speed <= (count_r != '0) ? cfg.forward_speed : '0;
      out_data_r.angular_rate <= (count_r != '0) ? rate : '0;
      out_data_r.white_count  <= count_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/white_blob_centroid_steering.sv -----
// Top level of the white blob centroid steering block.
//
// Pixels arrive on the in_ channel (valid/ready), one per cycle at full rate,
// each with its column and an end-of-frame mark. White pixels (all three
// channels equal to white_level) add their doubled centre offset to a sum and
// bump a count. The end-of-frame pixel closes the frame: its totals go into a
// queue of FIFO_DEPTH frames and the accumulators clear for the next frame.
// The back end pops one frame, forms turn_scale*|sum| and 2*count*width in
// the BK_MUL_NUM and BK_MUL_DEN states, checks the quotient range, then runs
// a restoring divider at one quotient bit a cycle. It skips the divider
// when no white pixel was seen, the width is zero or the rate saturates,
// and it takes no new frame until its command has been loaded into the
// output register.
// If the receiver stalls, the command holds in the output register; pixels
// keep flowing until the frame queue fills, and only then in_ready drops.
// The cfg_ port writes a register; the user must do so only while the block
// is idle, as the block does not enforce it. Reset (synchronous, rst_n low)
// restores register defaults, clears accumulators and empties the queue.
module white_blob_centroid_steering #(
  parameter int unsigned FIFO_DEPTH = wbcs_pkg::FIFO_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  wbcs_pkg::pixel_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output wbcs_pkg::cmd_t                    out_data,
  input  logic                              cfg_we,
  input  logic [wbcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wbcs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  wbcs_pkg::cfg_t   cfg_r;
  wbcs_pkg::frame_t q_wdata, q_rdata;
  logic             q_full, q_push, q_pop, q_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width   <= wbcs_pkg::RST_IMAGE_WIDTH;
      cfg_r.white_level   <= wbcs_pkg::RST_WHITE_LEVEL;
      cfg_r.forward_speed <= wbcs_pkg::RST_FORWARD_SPEED;
      cfg_r.turn_scale    <= wbcs_pkg::RST_TURN_SCALE;
    end else if (cfg_we) begin
      case (wbcs_pkg::cfg_reg_t'(cfg_index))
        wbcs_pkg::REG_IMAGE_WIDTH:
          cfg_r.image_width   <= cfg_wdata[wbcs_pkg::WIDTH_W-1:0];
        wbcs_pkg::REG_WHITE_LEVEL:
          cfg_r.white_level   <= cfg_wdata[wbcs_pkg::LEVEL_W-1:0];
        wbcs_pkg::REG_FORWARD_SPEED:
          cfg_r.forward_speed <= cfg_wdata[wbcs_pkg::SPEED_W-1:0];
        wbcs_pkg::REG_TURN_SCALE:
          cfg_r.turn_scale    <= cfg_wdata[wbcs_pkg::SCALE_W-1:0];
        default:
          cfg_r <= cfg_r;
      endcase
    end
  end

  wbcs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  wbcs_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  wbcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- design/wbcs_checker.sv -----
// Port-level checker for the steering block, bound to the top level.
module wbcs_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input wbcs_pkg::cmd_t out_data
);

  // Hold a stalled command
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled command changed or dropped");

  // No command straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("command valid after reset");

  // Found flag agrees with the count
  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.ball_found == (out_data.white_count != '0))
    else $error("ball_found disagrees with white_count");

  // Drop both drive commands when nothing was seen
  a_no_ball_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ball_found |->
      out_data.linear_speed == '0 && out_data.angular_rate == '0)
    else $error("drive command without a ball");

endmodule

bind white_blob_centroid_steering wbcs_checker u_wbcs_checker (.*);

// ----- verif/white_blob_centroid_steering_test.sv -----
// Self-checking testbench for the white blob centroid steering block.
module white_blob_centroid_steering_test;

  localparam int     SETTLE_CYCLES  = 40;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam longint SUM_HI         = 2147483647;
  localparam longint SUM_LO         = -SUM_HI - 1;
  localparam longint RATE_HI        = 32767;
  localparam longint RATE_LO        = -32768;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  wbcs_pkg::pixel_t                in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b1;
  wbcs_pkg::cmd_t                  out_data;
  logic                            cfg_we    = 1'b0;
  logic [wbcs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wbcs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor copy of the registers and the frame accumulators
  wbcs_pkg::cfg_t                    cur_cfg;
  logic signed [wbcs_pkg::SUM_W-1:0] acc_sum   = '0;
  logic [wbcs_pkg::COUNT_W-1:0]      acc_count = '0;
  wbcs_pkg::cmd_t                    expected_cmds[$];

  bit src_idle_on  = 1'b0;
  bit sink_idle_on = 1'b0;
  int stall_left   = 0;
  int stall_cycles = 0;
  int mismatches   = 0;
  int cmds_checked = 0;
  int pixels_sent  = 0;
  int settings_run = 0;

  white_blob_centroid_steering dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Update the accumulators with one pixel; queue the command on frame end
  function automatic void track_pixel(input wbcs_pkg::pixel_t px);
    longint         off;
    longint         s;
    longint         num;
    longint         den;
    longint         ang;
    wbcs_pkg::cmd_t c;
    if (px.red_level == cur_cfg.white_level && px.green_level == cur_cfg.white_level &&
        px.blue_level == cur_cfg.white_level && acc_count != wbcs_pkg::COUNT_MAX) begin
      off = 2 * longint'(px.column) - longint'(cur_cfg.image_width);
      s = longint'(acc_sum) + off;
      if (s > SUM_HI) s = SUM_HI;
      else if (s < SUM_LO) s = SUM_LO;
      acc_sum = s[wbcs_pkg::SUM_W-1:0];
      acc_count = acc_count + 1'b1;
    end
    if (px.end_of_frame) begin
      ang = 0;
      if (acc_count != 0 && cur_cfg.image_width != 0) begin
        num = -(longint'(cur_cfg.turn_scale) * longint'(acc_sum));
        den = 2 * longint'(acc_count) * longint'(cur_cfg.image_width);
        ang = num / den;
        if (ang > RATE_HI) ang = RATE_HI;
        else if (ang < RATE_LO) ang = RATE_LO;
      end
      c.ball_found   = (acc_count != 0);
      c.linear_speed = (acc_count != 0) ? cur_cfg.forward_speed : '0;
      c.angular_rate = ang[wbcs_pkg::RATE_W-1:0];
      c.white_count  = acc_count;
      expected_cmds.push_back(c);
      acc_sum   = '0;
      acc_count = '0;
    end
  endfunction

  // Drive one pixel, with an optional gap first, and hold until accepted
  task automatic send_pixel(input wbcs_pkg::pixel_t px);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_pixel(px);
    pixels_sent++;
  endtask

  function automatic wbcs_pkg::pixel_t mk_pixel(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b, input int col,
                                                input bit eof);
    wbcs_pkg::pixel_t px;
    px.red_level    = r;
    px.green_level  = g;
    px.blue_level   = b;
    px.column       = col[wbcs_pkg::COLUMN_W-1:0];
    px.end_of_frame = eof;
    return px;
  endfunction

  // Drop valid and wait for every command, then let the back end settle
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input wbcs_pkg::cfg_reg_t idx,
                         input logic [wbcs_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Write all four registers back to back; block must be idle
  task automatic program_regs(input int width, input int level, input int fspeed,
                              input int tscale);
    put_reg(wbcs_pkg::REG_IMAGE_WIDTH, width[wbcs_pkg::CFG_DATA_W-1:0]);
    put_reg(wbcs_pkg::REG_WHITE_LEVEL, level[wbcs_pkg::CFG_DATA_W-1:0]);
    put_reg(wbcs_pkg::REG_FORWARD_SPEED, fspeed[wbcs_pkg::CFG_DATA_W-1:0]);
    put_reg(wbcs_pkg::REG_TURN_SCALE, tscale[wbcs_pkg::CFG_DATA_W-1:0]);
    cfg_we <= 1'b0;
    cur_cfg.image_width   = width[wbcs_pkg::WIDTH_W-1:0];
    cur_cfg.white_level   = level[wbcs_pkg::LEVEL_W-1:0];
    cur_cfg.forward_speed = fspeed[wbcs_pkg::SPEED_W-1:0];
    cur_cfg.turn_scale    = tscale[wbcs_pkg::SCALE_W-1:0];
    settings_run++;
  endtask

  // Reset values: offsets about 640, near-white misses, then a frame with no ball
  task automatic test_default_regs();
    send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 0, 1'b0));
    send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 639, 1'b0));
    send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFE, 5, 1'b0));
    send_pixel(mk_pixel(8'hFE, 8'hFF, 8'hFF, 6, 1'b0));
    send_pixel(mk_pixel(8'hFF, 8'hFE, 8'hFF, 7, 1'b0));
    send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 1023, 1'b1));
    send_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 320, 1'b1));
    settle_block();
  endtask

  // Black as white level with full gain and speed, then full white with zero gain
  task automatic test_level_extremes();
    program_regs(1024, 0, 16'hFFFF, 15'h7FFF);
    send_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 0, 1'b0));
    send_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 1023, 1'b1));
    settle_block();
    program_regs(2047, 255, 0, 0);
    send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 512, 1'b1));
    settle_block();
  endtask

  // Zero width, column beyond width, rate saturation, white pixel not on frame end
  task automatic test_width_corners();
    program_regs(0, 8'hA5, 16'h1234, 15'h4000);
    send_pixel(mk_pixel(8'hA5, 8'hA5, 8'hA5, 1023, 1'b0));
    send_pixel(mk_pixel(8'hA5, 8'hA5, 8'hA5, 0, 1'b0));
    send_pixel(mk_pixel(8'hA5, 8'hA5, 8'hA5, 300, 1'b1));
    settle_block();
    program_regs(1, 8'h5A, 16'h8000, 15'h7FFF);
    send_pixel(mk_pixel(8'h5A, 8'h5A, 8'h5A, 1023, 1'b1));
    settle_block();
    program_regs(2, 8'h5A, 16'h0001, 15'h7FFF);
    send_pixel(mk_pixel(8'h5A, 8'h5A, 8'h5A, 0, 1'b1));
    send_pixel(mk_pixel(8'h5A, 8'h5A, 8'h5A, 1, 1'b1));
    settle_block();
    program_regs(2047, 8'h3C, 16'h00FF, 15'h2A55);
    send_pixel(mk_pixel(8'h3C, 8'h3C, 8'h3C, 1023, 1'b0));
    send_pixel(mk_pixel(8'h3C, 8'h3C, 8'h3C, 0, 1'b0));
    send_pixel(mk_pixel(8'h3C, 8'hC3, 8'h3C, 0, 1'b1));
    settle_block();
  endtask

  function automatic wbcs_pkg::pixel_t rand_pixel(input bit eof);
    wbcs_pkg::pixel_t px;
    logic [7:0]       lvl;
    int               w;
    lvl = cur_cfg.white_level;
    w   = int'(cur_cfg.image_width);
    px  = mk_pixel(lvl, lvl, lvl, 0, eof);
    case ($urandom_range(0, 3))
      0, 1: ;
      2: begin
        // near miss: spoil exactly one channel
        case ($urandom_range(0, 2))
          0: px.red_level   = lvl ^ 8'($urandom_range(1, 255));
          1: px.green_level = lvl ^ 8'($urandom_range(1, 255));
          default: px.blue_level = lvl ^ 8'($urandom_range(1, 255));
        endcase
      end
      default: begin
        px.red_level   = 8'($urandom_range(0, 255));
        px.green_level = 8'($urandom_range(0, 255));
        px.blue_level  = 8'($urandom_range(0, 255));
      end
    endcase
    if (w >= 1 && w <= 1024 && $urandom_range(0, 4) != 0)
      px.column = wbcs_pkg::COLUMN_W'($urandom_range(0, w - 1));
    else
      px.column = wbcs_pkg::COLUMN_W'($urandom_range(0, 1023));
    return px;
  endfunction

  // Random frames under a series of register settings, extremes first
  task automatic test_random_frames();
    int width;
    int level;
    int fspeed;
    int tscale;
    int left;
    int flen;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin width = 1; level = 0; fspeed = 0; tscale = 0; end
        1: begin width = 2047; level = 255; fspeed = 16'hFFFF; tscale = 15'h7FFF; end
        default: begin
          case ($urandom_range(0, 5))
            0: width = 0;
            1: width = 1;
            2: width = 1024;
            3: width = 2047;
            default: width = $urandom_range(1, 1024);
          endcase
          level  = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 255);
          fspeed = $urandom_range(0, 16'hFFFF);
          tscale = ($urandom_range(0, 3) == 0) ? 15'h7FFF : $urandom_range(0, 15'h7FFF);
        end
      endcase
      program_regs(width, level, fspeed, tscale);
      // no idling in the fourth phase and in the last one
      src_idle_on  = (phase != 3 && phase != 7);
      sink_idle_on = (phase != 3 && phase != 7);
      left = 50;
      while (left > 0) begin
        flen = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
        if (flen > left) flen = left;
        for (int i = 0; i < flen; i++) send_pixel(rand_pixel(i == flen - 1));
        left -= flen;
      end
      settle_block();
    end
  endtask

  // Receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 13);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic report_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each command transaction with the oldest expectation
  always @(posedge clk) begin : check_cmds
    wbcs_pkg::cmd_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected command, expected none, actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = expected_cmds.pop_front();
        cmds_checked++;
        report_field("ball_found", longint'(want.ball_found),
                     longint'(out_data.ball_found));
        report_field("linear_speed", longint'(want.linear_speed),
                     longint'(out_data.linear_speed));
        report_field("angular_rate", longint'(want.angular_rate),
                     longint'(out_data.angular_rate));
        report_field("white_count", longint'(want.white_count),
                     longint'(out_data.white_count));
      end
    end
  end

  // Count cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles, %0d commands outstanding", $time,
             stall_cycles, expected_cmds.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : run_tests
    cur_cfg.image_width   = wbcs_pkg::RST_IMAGE_WIDTH;
    cur_cfg.white_level   = wbcs_pkg::RST_WHITE_LEVEL;
    cur_cfg.forward_speed = wbcs_pkg::RST_FORWARD_SPEED;
    cur_cfg.turn_scale    = wbcs_pkg::RST_TURN_SCALE;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_regs();
    test_level_extremes();
    test_width_corners();
    test_random_frames();
    settle_block();
    $display("Checked %0d commands from %0d pixels under %0d register settings.",
             cmds_checked, pixels_sent, settings_run);
    $display("Included zero width, both white level extremes and rate saturation.");
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
design/wbcs_pkg.sv
design/wbcs_front.sv
design/wbcs_queue.sv
design/wbcs_back.sv
design/white_blob_centroid_steering.sv
design/wbcs_checker.sv
verif/white_blob_centroid_steering_test.sv
